### hw/rtl/sse_pkg.sv
// Shared types and constants for the scale-space extremum detector.
package sse_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 2048;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned RowBits    = $clog2(MaxHeight);
  localparam int unsigned GeomBits   = 12;
  localparam int unsigned MarginBits = 10;
  localparam int unsigned ThreshBits = 15;
  localparam int unsigned CfgDataBits = 16;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef enum logic [1:0] {
    RegFrameWidth        = 2'd0,
    RegFrameHeight       = 2'd1,
    RegBorderMargin      = 2'd2,
    RegContrastThreshold = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    sample_t lower_sample;
    sample_t middle_sample;
    sample_t upper_sample;
  } in_word_t;

  typedef struct packed {
    logic [RowBits-1:0] center_row;
    logic [ColBits-1:0] center_col;
    sample_t            center_value;
    logic               is_extremum;
  } out_word_t;

  // One window column of one layer: oldest line on top.
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } sse_col_t;

  typedef struct packed {
    logic above;
    logic below;
  } sse_cmp_t;

endpackage

### hw/rtl/scale_space_extremum_detect.sv
// Top level of the 3x3x3 scale-space extremum detector.
//
// Input words carry one co-located lower/middle/upper DoG sample triple in
// raster order on a valid/ready channel. For every window center inside the
// border margin one output word is given: center row, column, middle-layer
// value and the extremum flag. Other pixels give no word.
// Throughput is one word per cycle unless the receiver stalls; an accepted
// word passes the line RAM read register, the cell chain and then the 3x3x3
// compare into the output register. The pipeline moves as one: when the output
// word is held by a stalled receiver, in_ready_o drops and all stages hold.
// Configuration writes (width, height, margin, threshold) are taken at any
// time on the cfg channel and are meant for an idle block; a width or height
// write restarts the frame at row 0, column 0.
// Reset clears the counters and the pipeline valids and loads the register
// defaults 640, 480, 5, 0. Line RAM contents are not cleared; a window only
// uses lines written earlier in the same frame.
module scale_space_extremum_detect (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sse_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sse_pkg::out_word_t                out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  sse_pkg::cfg_reg_e                 cfg_index_i,
  input  logic [sse_pkg::CfgDataBits-1:0]   cfg_data_i
);

  localparam int unsigned SB = sse_pkg::SampleBits;
  localparam int unsigned CB = sse_pkg::ColBits;
  localparam int unsigned RB = sse_pkg::RowBits;
  localparam int unsigned GB = sse_pkg::GeomBits;
  localparam int unsigned MB = sse_pkg::MarginBits;
  localparam int unsigned TB = sse_pkg::ThreshBits;
  localparam logic [GB-1:0] MinGeom = GB'(3);
  localparam logic [GB-1:0] MaxW    = GB'(sse_pkg::MaxWidth);
  localparam logic [GB-1:0] MaxH    = GB'(sse_pkg::MaxHeight);

  // configuration
  logic [GB-1:0] frame_width_q, frame_height_q;
  logic [MB-1:0] margin_q;
  logic [TB-1:0] thresh_q;
  logic          cfg_we, restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign restart     = cfg_we && (cfg_index_i == sse_pkg::RegFrameWidth ||
                                  cfg_index_i == sse_pkg::RegFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= GB'(640);
      frame_height_q <= GB'(480);
      margin_q       <= MB'(5);
      thresh_q       <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        sse_pkg::RegFrameWidth:        frame_width_q  <= cfg_data_i[GB-1:0];
        sse_pkg::RegFrameHeight:       frame_height_q <= cfg_data_i[GB-1:0];
        sse_pkg::RegBorderMargin:      margin_q       <= cfg_data_i[MB-1:0];
        sse_pkg::RegContrastThreshold: thresh_q       <= cfg_data_i[TB-1:0];
        default: ;
      endcase
    end
  end

  logic [GB-1:0] w, h;
  assign w = (frame_width_q < MinGeom) ? MinGeom :
             (frame_width_q > MaxW) ? MaxW : frame_width_q;
  assign h = (frame_height_q < MinGeom) ? MinGeom :
             (frame_height_q > MaxH) ? MaxH : frame_height_q;

  // pipeline control
  logic adv, accept;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // stage 0: position counters and window-center test
  logic [RB-1:0] row_q, row_d, r;
  logic [CB-1:0] col_q, col_d, c;
  logic [RB-1:0] cr;
  logic [CB-1:0] cc;
  logic          produce;

  always_comb begin
    r = row_q;
    c = col_q;
    if ({1'b0, col_q} >= w || {1'b0, row_q} >= h) begin
      r = '0;
      c = '0;
    end
    cr = r - RB'(1);
    cc = c - CB'(1);
    produce = (r >= RB'(2)) && (c >= CB'(2)) &&
              (cr >= RB'(margin_q)) &&
              (({1'b0, cr} + GB'(margin_q)) <= (h - GB'(1))) &&
              (cc >= CB'(margin_q)) &&
              (({1'b0, cc} + GB'(margin_q)) <= (w - GB'(1)));
    if (({1'b0, c} + GB'(1)) >= w) begin
      col_d = '0;
      row_d = (({1'b0, r} + GB'(1)) >= h) ? '0 : r + RB'(1);
    end else begin
      col_d = c + CB'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (restart) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // stage 1: line RAM read data available
  logic              s1_valid_q, s1_prod_q;
  sse_pkg::in_word_t s1_word_q;
  logic [CB-1:0]     s1_col_q, s1_cc_q;
  logic [RB-1:0]     s1_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= in_word_i;
      s1_col_q  <= c;
      s1_prod_q <= produce;
      s1_cr_q   <= cr;
      s1_cc_q   <= cc;
    end
  end

  // Each RAM entry holds {previous line, line before} for one column.
  logic              shift_en;
  sse_pkg::sample_t  new_smp [3];
  sse_pkg::sse_col_t new_col [3];
  logic [2*SB-1:0]   rd [3];

  assign shift_en   = s1_valid_q && adv;
  assign new_smp[0] = s1_word_q.lower_sample;
  assign new_smp[1] = s1_word_q.middle_sample;
  assign new_smp[2] = s1_word_q.upper_sample;

  // stage 2: window held in the cell chain
  sse_pkg::sse_col_t cell_col [3][3];
  sse_pkg::sse_cmp_t cell_cmp [3][3];
  sse_pkg::sample_t  center;

  assign center = cell_col[1][1].mid;

  for (genvar l = 0; l < 3; l++) begin : g_layer
    sse_ram #(
      .Width(2 * SB),
      .Depth(sse_pkg::MaxWidth)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (shift_en),
      .waddr_i (s1_col_q),
      .wdata_i ({new_smp[l], rd[l][2*SB-1:SB]}),
      .re_i    (accept),
      .raddr_i (c),
      .rdata_o (rd[l])
    );

    assign new_col[l].top = rd[l][SB-1:0];
    assign new_col[l].mid = rd[l][2*SB-1:SB];
    assign new_col[l].bot = new_smp[l];

    for (genvar k = 0; k < 3; k++) begin : g_cell
      sse_pkg::sse_col_t cin;
      if (k == 2) begin : g_head
        assign cin = new_col[l];
      end else begin : g_link
        assign cin = cell_col[l][k+1];
      end
      sse_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (shift_en),
        .col_i    (cin),
        .center_i (center),
        .col_o    (cell_col[l][k]),
        .cmp_o    (cell_cmp[l][k])
      );
    end
  end

  logic          s2_valid_q, s2_prod_q;
  logic [RB-1:0] s2_cr_q;
  logic [CB-1:0] s2_cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      s2_prod_q <= s1_prod_q;
      s2_cr_q   <= s1_cr_q;
      s2_cc_q   <= s1_cc_q;
    end
  end

  logic          above, below, big, flag;
  logic [SB:0]   mag;

  always_comb begin
    above = 1'b0;
    below = 1'b0;
    for (int l = 0; l < 3; l++) begin
      for (int k = 0; k < 3; k++) begin
        above = above | cell_cmp[l][k].above;
        below = below | cell_cmp[l][k].below;
      end
    end
    mag  = center[SB-1] ? -{center[SB-1], center} : {1'b0, center};
    big  = mag >= (SB+1)'(thresh_q);
    flag = big && !(above && below) &&
           ((!center[SB-1] && center != '0 && above) || (center[SB-1] && below));
  end

  // output register
  sse_pkg::out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q && s2_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_word_q.center_row   <= s2_cr_q;
      out_word_q.center_col   <= s2_cc_q;
      out_word_q.center_value <= center;
      out_word_q.is_extremum  <= flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### hw/rtl/sse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sse_cell.sv
// One window column of one layer: shifts to its neighbor and compares with the center.
module sse_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  sse_pkg::sse_col_t   col_i,
  input  sse_pkg::sample_t    center_i,
  output sse_pkg::sse_col_t   col_o,
  output sse_pkg::sse_cmp_t   cmp_o
);

  sse_pkg::sse_col_t col_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    cmp_o.above = (center_i > col_q.top) || (center_i > col_q.mid) ||
                  (center_i > col_q.bot);
    cmp_o.below = (center_i < col_q.top) || (center_i < col_q.mid) ||
                  (center_i < col_q.bot);
  end

  assign col_o = col_q;

endmodule
